### sv/assert_macros.svh
// Assertion helpers shared by the RTL; define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Condition must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/spr_pkg.sv
`default_nettype none
package spr_pkg;

  localparam int MAX_PACKETS_DEF    = 256;
  localparam int PACKET_SAMPLES_DEF = 44100;
  localparam int BANDS              = 256;
  localparam int CFG_DW             = 40;
  localparam int CFG_IW             = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_START_SAMPLE = 3'd0,
    CFG_PIXEL_STEP   = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_PACKET_COUNT = 3'd4,
    CFG_PIXEL_FORMAT = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FMT_FLAGS8 = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_RGB24  = 2'd2
  } fmt_t;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_RENDER = 1'b1
  } req_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  packet_index;
    logic [7:0]  band_index;
    logic [7:0]  band_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [23:0] pixel_word;
  } out_t;

endpackage
`default_nettype wire

### sv/spr_ram.sv
`default_nettype none
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a_r,
  output logic      [WIDTH-1:0]         rdata_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### sv/spr_cdiv.sv
`default_nettype none
module spr_cdiv #(
  parameter int N = 32,
  parameter int D = 44100
) (
  input  wire logic                     clk,
  input  wire logic [N-1:0]             num,
  output logic      [N-1:0]             quo_r,
  output logic      [$clog2(D+1)-1:0]   rem_r
);

  localparam int RW = $clog2(D + 1);
  localparam longint unsigned MULL = (64'd1 << N) / D;
  localparam logic [N:0]   MUL = MULL[N:0];
  localparam logic [N-1:0] DV  = N'(D);

  logic [2*N:0] prod_r;
  logic [N-1:0] n1_r, n2_r, n3_r, est_r, est3_r, back_r;
  logic [N-1:0] diff;
  logic         over;

  // reciprocal estimate is exact or one short; fix with one subtract
  always_ff @(posedge clk) begin
    prod_r <= (2*N+1)'(num) * (2*N+1)'(MUL);
    n1_r   <= num;
    est_r  <= prod_r[2*N-1:N];
    n2_r   <= n1_r;
    back_r <= N'(est_r * DV);
    est3_r <= est_r;
    n3_r   <= n2_r;
    quo_r  <= over ? est3_r + N'(1) : est3_r;
    rem_r  <= over ? RW'(diff - DV) : RW'(diff);
  end

  assign diff = n3_r - back_r;
  assign over = (diff >= DV);

endmodule
`default_nettype wire

### sv/spectrogram_pixel_renderer.sv
`default_nettype none
// Spectrogram pixel renderer.
// Input: drive in_data and pulse start; a beat is taken on any edge with start
// high, busy is always low, so one beat per cycle is sustained.
// A write beat (req_type 0) stores band_value at (packet_index, band_index)
// in the band store; it gives no result.
// A render beat (req_type 1) gives at most one result: out_strobe is high for
// one cycle with out_data holding x, y and the packed pixel word. Pixels off
// the image, rows 256 and up, or zoomed out past the stored packets give none.
// Throughput is one item per cycle. The pipeline length is set by the two
// constant dividers on the beat's path and the band store read.
// The receiver cannot stall: results leave on the following edge.
// Configuration: cfg_we, cfg_index, cfg_wdata; write only while no render is
// in flight. Reset clears config registers to their defaults and the pipeline
// valid bits; the band store is not cleared and holds garbage until written.
module spectrogram_pixel_renderer
  import spr_pkg::*;
#(
  parameter int MAX_PACKETS    = MAX_PACKETS_DEF,
  parameter int PACKET_SAMPLES = PACKET_SAMPLES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               in_data,
  output logic                   out_strobe,
  output out_t                   out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam int PKW   = $clog2(MAX_PACKETS);
  localparam int AW    = PKW + 8;
  localparam int DEPTH = MAX_PACKETS * BANDS;
  localparam int CNW   = $clog2(MAX_PACKETS + 1);
  localparam longint unsigned SPAN = 64'(PACKET_SAMPLES) << 16;
  localparam int SPW   = $clog2(SPAN);
  localparam int POSW  = ((47 > 12 + SPW) ? 47 : 12 + SPW) + 1;
  localparam int QW    = POSW - 16;
  localparam int RMW   = $clog2(PACKET_SAMPLES + 1);
  localparam int RNW   = $clog2(PACKET_SAMPLES * 256);
  localparam int LAT   = 13;

  typedef struct packed {
    logic        is_wr;
    logic [7:0]  wpk;
    logic [7:0]  wband;
    logic [7:0]  wval;
    logic [11:0] x;
    logic [11:0] y;
    logic        ok;
    logic        zin;
    logic [7:0]  frac8;
  } pipe_t;

  // configuration registers
  logic [30:0] start_sample_r;
  logic [39:0] pixel_step_r;
  logic [12:0] image_width_r, image_height_r;
  logic [8:0]  packet_count_r;
  logic [1:0]  pixel_format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_sample_r <= '0;
      pixel_step_r   <= 40'd65536;
      image_width_r  <= 13'd1;
      image_height_r <= 13'd1;
      packet_count_r <= 9'd1;
      pixel_format_r <= FMT_RGB24;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_SAMPLE: start_sample_r <= cfg_wdata[30:0];
        CFG_PIXEL_STEP:   pixel_step_r   <= cfg_wdata[39:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[12:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[12:0];
        CFG_PACKET_COUNT: packet_count_r <= cfg_wdata[8:0];
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [CNW-1:0] cnt;
  assign cnt = (32'(packet_count_r) < 32'(MAX_PACKETS)) ? CNW'(packet_count_r)
                                                        : CNW'(MAX_PACKETS);

  assign busy = 1'b0;

  logic  acc;
  assign acc = start && !busy;

  // stage 1: capture the beat
  logic  v1_r;
  in_t   s1_r;
  // stage 2: position and checks
  logic  v2_r;
  pipe_t p2_r, p2_nxt;
  logic [POSW-1:0] pos_r, pos_nxt;
  pipe_t pd0_nxt;
  // stages 3..6 wait on the position divider
  logic  vd_r [4];
  pipe_t pd_r [4];
  // stage 7: store access
  logic  v7_r, emit7_r, clamp7_r;
  pipe_t p7_r;
  logic [AW-1:0]  addr_a_r, addr_b_r;
  logic [RNW-1:0] r_r;
  // stages 8..11 wait on the weight divider
  logic  ve_r [4];
  logic  emit_e_r [4];
  logic  clamp_e_r [4];
  pipe_t pe_r [4];
  logic [7:0] ba_r [3];
  logic [7:0] bb_r [3];
  // stages 12..14
  logic        emit12_r, emit13_r, out_strobe_r;
  logic [11:0] x12_r, y12_r, x13_r, y13_r;
  logic [7:0]  level_r, red_r, green_r;
  out_t        out_data_r;

  logic [QW-1:0]  quo_a;
  logic [RMW-1:0] rem_a;
  logic [30:0]    quo_s;
  logic [RMW-1:0] rem_s;
  logic [RNW-1:0] quo_b;
  logic [RMW-1:0] rem_b;
  logic [7:0]     rd_a, rd_b;

  // stage 2 logic
  always_comb begin
    p2_nxt       = '0;
    p2_nxt.is_wr = (s1_r.req_type == REQ_WRITE);
    p2_nxt.wpk   = s1_r.packet_index;
    p2_nxt.wband = s1_r.band_index;
    p2_nxt.wval  = s1_r.band_value;
    p2_nxt.x     = s1_r.pixel_x;
    p2_nxt.y     = s1_r.pixel_y;
    p2_nxt.ok    = (cnt != '0) && ({1'b0, s1_r.pixel_x} < image_width_r) &&
                   ({1'b0, s1_r.pixel_y} < image_height_r) &&
                   (s1_r.pixel_y[11:8] == 4'd0);
    p2_nxt.zin   = (64'(pixel_step_r) < SPAN);
    pos_nxt      = POSW'({start_sample_r, 16'd0}) +
                   POSW'(s1_r.pixel_x) * POSW'(pixel_step_r[SPW-1:0]);
  end

  // attach the fraction bits to the beat entering the divider wait
  always_comb begin
    pd0_nxt       = p2_r;
    pd0_nxt.frac8 = pos_r[15:8];
  end

  spr_cdiv #(.N(QW), .D(PACKET_SAMPLES)) u_div_pos (
    .clk(clk), .num(pos_r[POSW-1:16]), .quo_r(quo_a), .rem_r(rem_a)
  );

  spr_cdiv #(.N(31), .D(PACKET_SAMPLES)) u_div_start (
    .clk(clk), .num(start_sample_r), .quo_r(quo_s), .rem_r(rem_s)
  );

  // stage 6 logic: packet selection and clamping
  pipe_t          p6;
  logic           v6, clamp6, zdrop6, emit6;
  logic [PKW-1:0] lo6, hi6, zpk6;
  logic [CNW:0]   lo1;
  logic [31:0]    zpk_full;
  logic [AW-1:0]  addr_a_nxt, addr_b_nxt;
  logic [RNW-1:0] r_nxt;

  always_comb begin
    p6       = pd_r[3];
    v6       = vd_r[3];
    clamp6   = (64'(quo_a) >= 64'(cnt));
    lo6      = clamp6 ? PKW'(cnt - CNW'(1)) : PKW'(quo_a);
    lo1      = (CNW+1)'(lo6) + (CNW+1)'(1);
    hi6      = (lo1 < (CNW+1)'(cnt)) ? PKW'(lo1) : PKW'(cnt - CNW'(1));
    zpk_full = 32'(quo_s) + 32'(p6.x);
    zdrop6   = (zpk_full >= 32'(cnt));
    zpk6     = PKW'(zpk_full);
    emit6    = v6 && !p6.is_wr && p6.ok && (p6.zin || !zdrop6);
    addr_a_nxt = {(p6.zin ? lo6 : zpk6), p6.y[7:0]};
    addr_b_nxt = {hi6, p6.y[7:0]};
    r_nxt    = RNW'({rem_a, p6.frac8});
  end

  // stage 7: band store write and reads
  logic           st_we;
  logic [AW-1:0]  st_waddr;
  assign st_we    = v7_r && p7_r.is_wr && (32'(p7_r.wpk) < 32'(MAX_PACKETS));
  assign st_waddr = {PKW'(p7_r.wpk), p7_r.wband};

  spr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(p7_r.wval),
    .raddr_a(addr_a_r), .raddr_b(addr_b_r), .rdata_a_r(rd_a), .rdata_b_r(rd_b)
  );

  spr_cdiv #(.N(RNW), .D(PACKET_SAMPLES)) u_div_frac (
    .clk(clk), .num(r_r), .quo_r(quo_b), .rem_r(rem_b)
  );

  // stage 11 logic: blend
  logic [7:0] w11, a11, b11;
  logic [15:0] ta, tb;
  logic [8:0]  sum11;
  logic [7:0]  level_nxt;
  always_comb begin
    a11       = ba_r[2];
    b11       = bb_r[2];
    w11       = clamp_e_r[3] ? 8'd255 : quo_b[7:0];
    ta        = 16'(8'd255 - w11) * 16'(a11);
    tb        = 16'(w11) * 16'(b11);
    sum11     = 9'(ta[15:8]) + 9'(tb[15:8]);
    level_nxt = sum11[8] ? 8'd255 : sum11[7:0];
    if (!pe_r[3].zin) begin
      level_nxt = a11;
    end
  end

  // stage 12 logic: color map
  logic [15:0] red_p;
  logic [16:0] green_p;
  assign red_p   = 16'(y12_r[7:0]) * 16'(level_r);
  assign green_p = (17'd256 - 17'(y12_r[7:0])) * 17'(level_r);

  // stage 13 logic: pack
  logic [23:0] word13;
  always_comb begin
    case (fmt_t'(pixel_format_r))
      FMT_FLAGS8: word13 = {21'd0, red_r[7], green_r[7], 1'b0};
      FMT_RGB555: word13 = {14'd0, green_r[7:3], red_r[7:3]};
      FMT_RGB24:  word13 = {red_r, green_r, 8'd0};
      default:    word13 = 24'd0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v7_r         <= 1'b0;
      emit7_r      <= 1'b0;
      emit12_r     <= 1'b0;
      emit13_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        vd_r[i]     <= 1'b0;
        ve_r[i]     <= 1'b0;
        emit_e_r[i] <= 1'b0;
      end
    end else begin
      v1_r     <= acc;
      v2_r     <= v1_r;
      vd_r[0]  <= v2_r;
      for (int i = 1; i < 4; i++) begin
        vd_r[i]     <= vd_r[i-1];
        ve_r[i]     <= ve_r[i-1];
        emit_e_r[i] <= emit_e_r[i-1];
      end
      v7_r         <= v6;
      emit7_r      <= emit6;
      ve_r[0]      <= v7_r;
      emit_e_r[0]  <= emit7_r;
      emit12_r     <= emit_e_r[3] && ve_r[3];
      emit13_r     <= emit12_r;
      out_strobe_r <= emit13_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= in_data;
    end
    p2_r  <= p2_nxt;
    pos_r <= pos_nxt;
    pd_r[0] <= pd0_nxt;
    for (int i = 1; i < 4; i++) begin
      pd_r[i]      <= pd_r[i-1];
      pe_r[i]      <= pe_r[i-1];
      clamp_e_r[i] <= clamp_e_r[i-1];
    end
    p7_r         <= p6;
    clamp7_r     <= clamp6;
    addr_a_r     <= addr_a_nxt;
    addr_b_r     <= addr_b_nxt;
    r_r          <= r_nxt;
    pe_r[0]      <= p7_r;
    clamp_e_r[0] <= clamp7_r;
    ba_r[0]      <= rd_a;
    bb_r[0]      <= rd_b;
    for (int i = 1; i < 3; i++) begin
      ba_r[i] <= ba_r[i-1];
      bb_r[i] <= bb_r[i-1];
    end
    level_r <= level_nxt;
    x12_r   <= pe_r[3].x;
    y12_r   <= pe_r[3].y;
    red_r   <= red_p[15:8];
    green_r <= green_p[15:8];
    x13_r   <= x12_r;
    y13_r   <= y12_r;
    out_data_r <= '{out_x: x13_r, out_y: y13_r, pixel_word: word13};
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `ASSERT_IMP(a_out_from_render, clk, rst_n, out_strobe,
              $past(start && !busy && in_data.req_type == REQ_RENDER, LAT + 1))
  `ASSERT_IMP(a_out_row, clk, rst_n, out_strobe, out_data.out_y[11:8] == 4'd0)
  `ASSERT_IMP(a_out_col, clk, rst_n, out_strobe,
              {1'b0, out_data.out_x} < image_width_r)
  `ASSERT_NEVER(a_no_busy, clk, rst_n, busy)

endmodule
`default_nettype wire
